/* rtl/insphere_sign_predicate_core_defines.svh */
// Assertion macros shared by the insphere predicate RTL.
`ifndef INSPHERE_SIGN_PREDICATE_CORE_DEFINES_SVH
`define INSPHERE_SIGN_PREDICATE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define ISP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define ISP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/isp_pkg.sv */
// Types, widths and helper functions of the insphere sign predicate.
`default_nettype none
package isp_pkg;
  localparam int VERTEX_COUNT = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_W = 10;
  localparam int FIELD_W = 16;
  localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 2;
  localparam int AW = PW + 1;
  localparam int ZW = DW + WW;
  localparam int BW = ZW + 1;
  localparam int SPLIT = BW / 2;
  localparam int HW = BW - SPLIT;
  localparam int LW = SPLIT + 1;
  localparam int TW = AW + BW;
  localparam int DETW = TW + 3;
  localparam int READS = 5;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_POINT  = 2'd1,
    REQ_STORED = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [1:0] SIDE_ZERO = 2'b00;
  localparam logic [1:0] SIDE_POS = 2'b01;
  localparam logic [1:0] SIDE_NEG = 2'b11;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  function automatic coord_t coord_of(input logic [FIELD_W-1:0] raw);
    logic [31:0] ext;
    ext = {{(32-FIELD_W){1'b0}}, raw};
    return coord_t'(ext[COORD_BITS-1:0]);
  endfunction

  function automatic diff_t widen(input coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = {{(32-IDX_W){1'b0}}, idx};
    return ext < 32'(VERTEX_COUNT);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = {{(32-IDX_W){1'b0}}, idx};
    return ext[ADDR_W-1:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/insphere_sign_predicate_core.sv */
// Insphere sign predicate: vertex store and exact determinant pipeline.
`default_nettype none
`include "insphere_sign_predicate_core_defines.svh"

// Write transactions fill a vertex store; query transactions return the exact sign of
// the 4x4 insphere determinant of four stored corners against a test point. The block
// takes one transaction per clock while the output is not stalled. A query result passes
// through the store read register, nine arithmetic stages and the output register.
// The store is held in five copies, one per read port (test point and four corners),
// so every query reads all of its vertices in its accept cycle. A stalled output freezes
// the whole pipeline. Reading a never-written vertex gives an undefined result.
module insphere_sign_predicate_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // Fields from bit 0: vertex_index, coord_x, coord_y, coord_z,
  // corner_a, corner_b, corner_c, corner_d, zero fill.
  input  wire logic [103:0] s_tdata,
  // Fields from bit 0: req_type.
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // Fields from bit 0: side, zero fill.
  output logic [7:0]        m_tdata
);
  localparam int NST = 10;
  localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [6] = '{1, 2, 3, 2, 3, 3};

  logic en;
  logic acc;
  isp_pkg::req_t req;
  isp_pkg::vertex_t vin;
  logic [isp_pkg::IDX_W-1:0] rdidx [isp_pkg::READS];
  logic [NST:1] vld;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc = s_tvalid && s_tready;
  assign req = isp_pkg::req_t'(s_tuser);
  assign vin.x = isp_pkg::coord_of(s_tdata[25:10]);
  assign vin.y = isp_pkg::coord_of(s_tdata[41:26]);
  assign vin.z = isp_pkg::coord_of(s_tdata[57:42]);
  assign rdidx[0] = s_tdata[9:0];
  assign rdidx[1] = s_tdata[67:58];
  assign rdidx[2] = s_tdata[77:68];
  assign rdidx[3] = s_tdata[87:78];
  assign rdidx[4] = s_tdata[97:88];

  isp_pkg::vertex_t rd1 [isp_pkg::READS];
  logic ok1 [isp_pkg::READS];
  isp_pkg::vertex_t pin1;
  logic stored1;

  for (genvar g = 0; g < isp_pkg::READS; g++) begin : g_copy
    isp_pkg::vertex_t mem [isp_pkg::VERTEX_COUNT];
    isp_pkg::vertex_t rd;
    logic ok;
    always_ff @(posedge clk) begin
      if (acc && req == isp_pkg::REQ_WRITE && isp_pkg::idx_ok(rdidx[0])) begin
        mem[isp_pkg::addr_of(rdidx[0])] <= vin;
      end
      if (en) begin
        rd <= mem[isp_pkg::addr_of(rdidx[g])];
        ok <= isp_pkg::idx_ok(rdidx[g]);
      end
    end
    assign rd1[g] = rd;
    assign ok1[g] = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[NST-1:1],
              acc && (req == isp_pkg::REQ_POINT || req == isp_pkg::REQ_STORED)};
      m_tvalid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pin1 <= vin;
      stored1 <= (req == isp_pkg::REQ_STORED);
    end
  end

  isp_pkg::vertex_t pt2;
  isp_pkg::vertex_t cv2 [4];
  isp_pkg::diff_t dx2 [4], dy2 [4], dz2 [4], sx2 [4], sy2 [4], sz2 [4];
  logic signed [isp_pkg::PW-1:0] qx3 [4], qy3 [4], qz3 [4];
  isp_pkg::diff_t x3 [4], y3 [4], z3 [4];
  logic signed [isp_pkg::WW-1:0] w4 [4];
  isp_pkg::diff_t z4 [4];
  logic signed [isp_pkg::PW-1:0] mp4 [6], mn4 [6];
  logic signed [isp_pkg::AW-1:0] a5 [6], a6 [6];
  logic signed [isp_pkg::ZW-1:0] zp5 [6], zn5 [6];
  logic signed [isp_pkg::BW-1:0] b6 [6];
  logic signed [isp_pkg::AW+isp_pkg::HW-1:0] ph7 [6];
  logic signed [isp_pkg::AW+isp_pkg::LW-1:0] pl7 [6];
  logic signed [isp_pkg::TW-1:0] t8 [6];
  logic signed [isp_pkg::DETW-1:0] g9 [3];
  logic signed [isp_pkg::DETW-1:0] det10;

  always_comb begin
    pt2 = stored1 ? (ok1[0] ? rd1[0] : '0) : pin1;
  end

  for (genvar k = 0; k < 4; k++) begin : g_corner
    assign cv2[k] = ok1[k+1] ? rd1[k+1] : '0;
    always_ff @(posedge clk) begin
      if (en) begin
        dx2[k] <= isp_pkg::widen(cv2[k].x) - isp_pkg::widen(pt2.x);
        dy2[k] <= isp_pkg::widen(cv2[k].y) - isp_pkg::widen(pt2.y);
        dz2[k] <= isp_pkg::widen(cv2[k].z) - isp_pkg::widen(pt2.z);
        sx2[k] <= isp_pkg::widen(cv2[k].x) + isp_pkg::widen(pt2.x);
        sy2[k] <= isp_pkg::widen(cv2[k].y) + isp_pkg::widen(pt2.y);
        sz2[k] <= isp_pkg::widen(cv2[k].z) + isp_pkg::widen(pt2.z);
        qx3[k] <= sx2[k] * dx2[k];
        qy3[k] <= sy2[k] * dy2[k];
        qz3[k] <= sz2[k] * dz2[k];
        x3[k] <= dx2[k];
        y3[k] <= dy2[k];
        z3[k] <= dz2[k];
        w4[k] <= isp_pkg::WW'(qx3[k]) + isp_pkg::WW'(qy3[k]) + isp_pkg::WW'(qz3[k]);
        z4[k] <= z3[k];
      end
    end
  end

  for (genvar n = 0; n < 6; n++) begin : g_pair
    logic signed [isp_pkg::HW-1:0] bhi;
    logic signed [isp_pkg::LW-1:0] blo;
    logic signed [isp_pkg::TW-1:0] hi_ext;
    assign bhi = b6[5-n][isp_pkg::BW-1:isp_pkg::SPLIT];
    assign blo = $signed({1'b0, b6[5-n][isp_pkg::SPLIT-1:0]});
    assign hi_ext = isp_pkg::TW'(ph7[n]);
    always_ff @(posedge clk) begin
      if (en) begin
        mp4[n] <= x3[PAIR_I[n]] * y3[PAIR_J[n]];
        mn4[n] <= x3[PAIR_J[n]] * y3[PAIR_I[n]];
        a5[n] <= isp_pkg::AW'(mp4[n]) - isp_pkg::AW'(mn4[n]);
        zp5[n] <= z4[PAIR_I[n]] * w4[PAIR_J[n]];
        zn5[n] <= z4[PAIR_J[n]] * w4[PAIR_I[n]];
        a6[n] <= a5[n];
        b6[n] <= isp_pkg::BW'(zp5[n]) - isp_pkg::BW'(zn5[n]);
        ph7[n] <= a6[n] * bhi;
        pl7[n] <= a6[n] * blo;
        t8[n] <= (hi_ext <<< isp_pkg::SPLIT) + isp_pkg::TW'(pl7[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g9[0] <= isp_pkg::DETW'(t8[0]) - isp_pkg::DETW'(t8[1]);
      g9[1] <= isp_pkg::DETW'(t8[2]) + isp_pkg::DETW'(t8[3]);
      g9[2] <= isp_pkg::DETW'(t8[5]) - isp_pkg::DETW'(t8[4]);
      det10 <= g9[0] + g9[1] + g9[2];
      m_tdata[7:2] <= '0;
      if (det10[isp_pkg::DETW-1]) begin
        m_tdata[1:0] <= isp_pkg::SIDE_NEG;
      end else if (|det10) begin
        m_tdata[1:0] <= isp_pkg::SIDE_POS;
      end else begin
        m_tdata[1:0] <= isp_pkg::SIDE_ZERO;
      end
    end
  end

  `ISP_ASSERT_NXT(a_write_no_result, acc && req == isp_pkg::REQ_WRITE, !vld[1], "write made a result")
  `ISP_ASSERT_NXT(a_stall_freezes, m_tvalid && !m_tready, $stable(vld), "pipeline moved in stall")
  `ISP_ASSERT_IMP(a_side_code, m_tvalid, m_tdata[1:0] != 2'b10, "invalid side code")
endmodule
`default_nettype wire

/* sim/insphere_sign_predicate_core_checker.sv */
// Checker that predicts insphere signs from observed transactions and compares results.
`timescale 1ns / 100ps
module insphere_sign_predicate_core_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [103:0] s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [7:0]   m_tdata,
  output int                failures,
  output int                pending
);
  typedef logic signed [255:0] wide_t;

  isp_pkg::vertex_t shadow_store [isp_pkg::VERTEX_COUNT];
  logic [1:0]       side_queue [$];

  function automatic wide_t coord_wide(input logic [15:0] raw);
    return wide_t'(isp_pkg::coord_t'(raw[isp_pkg::COORD_BITS-1:0]));
  endfunction

  function automatic logic [1:0] insphere_side(input wide_t px, input wide_t py,
                                               input wide_t pz, input logic [39:0] corners);
    wide_t x[4], y[4], z[4], w[4];
    wide_t vx, vy, vz, det;
    wide_t a0, a1, a2, a3, a4, a5, b0, b1, b2, b3, b4, b5;
    isp_pkg::vertex_t v;
    logic [9:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx = corners[10*k +: 10];
      v = shadow_store[idx];
      vx = wide_t'(v.x);
      vy = wide_t'(v.y);
      vz = wide_t'(v.z);
      x[k] = vx - px;
      y[k] = vy - py;
      z[k] = vz - pz;
      w[k] = (vx + px) * x[k] + (vy + py) * y[k] + (vz + pz) * z[k];
    end
    a0 = x[0] * y[1] - x[1] * y[0];
    a1 = x[0] * y[2] - x[2] * y[0];
    a2 = x[0] * y[3] - x[3] * y[0];
    a3 = x[1] * y[2] - x[2] * y[1];
    a4 = x[1] * y[3] - x[3] * y[1];
    a5 = x[2] * y[3] - x[3] * y[2];
    b0 = z[0] * w[1] - z[1] * w[0];
    b1 = z[0] * w[2] - z[2] * w[0];
    b2 = z[0] * w[3] - z[3] * w[0];
    b3 = z[1] * w[2] - z[2] * w[1];
    b4 = z[1] * w[3] - z[3] * w[1];
    b5 = z[2] * w[3] - z[3] * w[2];
    det = a0 * b5 - a1 * b4 + a2 * b3 + a3 * b2 - a4 * b1 + a5 * b0;
    if (det < 0) return isp_pkg::SIDE_NEG;
    if (det > 0) return isp_pkg::SIDE_POS;
    return isp_pkg::SIDE_ZERO;
  endfunction

  assign pending = side_queue.size();

  always @(posedge clk) begin
    logic [1:0] want;
    isp_pkg::vertex_t tp;
    if (rst) begin
      failures <= 0;
      side_queue.delete();
      for (int i = 0; i < isp_pkg::VERTEX_COUNT; i++) shadow_store[i] = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (side_queue.size() == 0) begin
          $error("side: unexpected result %0d", m_tdata[1:0]);
          failures <= failures + 1;
        end else begin
          want = side_queue.pop_front();
          if (m_tdata[1:0] !== want || m_tdata[7:2] !== 6'd0) begin
            $error("side: expected %0d, actual %0d", want, m_tdata);
            failures <= failures + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (isp_pkg::req_t'(s_tuser))
          isp_pkg::REQ_WRITE: begin
            shadow_store[s_tdata[9:0]] = {isp_pkg::coord_t'(s_tdata[25:10]),
                                          isp_pkg::coord_t'(s_tdata[41:26]),
                                          isp_pkg::coord_t'(s_tdata[57:42])};
          end
          isp_pkg::REQ_POINT: side_queue.push_back(insphere_side(coord_wide(s_tdata[25:10]),
              coord_wide(s_tdata[41:26]), coord_wide(s_tdata[57:42]), s_tdata[97:58]));
          isp_pkg::REQ_STORED: begin
            tp = shadow_store[s_tdata[9:0]];
            side_queue.push_back(insphere_side(wide_t'(tp.x), wide_t'(tp.y), wide_t'(tp.z),
                                               s_tdata[97:58]));
          end
          default: ;
        endcase
      end
    end
  end
endmodule

/* sim/insphere_sign_predicate_core_test.sv */
// Testbench top: drives write and query transactions into the insphere core.
`timescale 1ns / 100ps
module insphere_sign_predicate_core_test;
  localparam int STALL_LIMIT = 2000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  int           failures;
  int           pending;
  int           idle_pct = 12;
  int           quiet_cycles = 0;
  bit           written [isp_pkg::VERTEX_COUNT];
  int           written_list [$];

  always #5 clk = ~clk;

  insphere_sign_predicate_core dut (.*);

  insphere_sign_predicate_core_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** insphere_sign_predicate_core: FAILED **");
      $finish;
    end
  end

  task automatic send(input isp_pkg::req_t kind, input logic [9:0] vidx,
                      input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz,
                      input logic [39:0] corners);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'd0, corners, cz, cy, cx, vidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == isp_pkg::REQ_WRITE && !written[vidx]) begin
      written[vidx] = 1'b1;
      written_list.push_back(vidx);
    end
  endtask

  function automatic logic [9:0] pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  function automatic logic [39:0] pick_corners();
    return {pick_written(), pick_written(), pick_written(), pick_written()};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [9:0] base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Corners on a unit-like sphere: extremes, cospherical and degenerate cases.
    send(isp_pkg::REQ_WRITE, 10'd0, 16'd1, 16'd0, 16'd0, '0);
    send(isp_pkg::REQ_WRITE, 10'd1, 16'hFFFF, 16'd0, 16'd0, '0);
    send(isp_pkg::REQ_WRITE, 10'd2, 16'd0, 16'd1, 16'd0, '0);
    send(isp_pkg::REQ_WRITE, 10'd3, 16'd0, 16'd0, 16'd1, '0);
    send(isp_pkg::REQ_WRITE, 10'd1023, 16'h7FFF, 16'h8000, 16'h7FFF, '0);
    send(isp_pkg::REQ_WRITE, 10'd4, 16'h8000, 16'h7FFF, 16'h8000, '0);
    send(isp_pkg::REQ_WRITE, 10'd5, 16'd0, 16'hFFFF, 16'd0, '0);
    send(isp_pkg::REQ_POINT, 10'd0, 16'd0, 16'd0, 16'd0, {10'd3, 10'd2, 10'd1, 10'd0});
    send(isp_pkg::REQ_POINT, 10'd0, 16'd0, 16'd0, 16'd0, {10'd2, 10'd3, 10'd1, 10'd0});
    send(isp_pkg::REQ_STORED, 10'd5, 16'd0, 16'd0, 16'd0, {10'd3, 10'd2, 10'd1, 10'd0});
    send(isp_pkg::REQ_POINT, 10'd0, 16'd5, 16'd5, 16'd5, {10'd3, 10'd2, 10'd1, 10'd0});
    send(isp_pkg::REQ_POINT, 10'd0, 16'd0, 16'd0, 16'd0, {10'd0, 10'd0, 10'd1, 10'd2});
    send(isp_pkg::REQ_POINT, 10'd0, 16'h8000, 16'h8000, 16'h8000,
         {10'd1023, 10'd4, 10'd2, 10'd0});
    send(isp_pkg::REQ_POINT, 10'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
         {10'd4, 10'd1023, 10'd3, 10'd1});
    send(isp_pkg::REQ_STORED, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         {10'd1023, 10'd4, 10'd5, 10'd3});
    send(isp_pkg::REQ_NONE, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
    send(isp_pkg::REQ_NONE, 10'd0, 16'd0, 16'd0, 16'd0, '0);
    // Hold off until every outstanding result has drained.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 310; n++) begin
      if (n == 100) idle_pct = 0;
      if (n == 180) idle_pct = 12;
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5:
          send(isp_pkg::REQ_WRITE, 10'($urandom), rand_coord(), rand_coord(), rand_coord(),
               40'($urandom));
        6, 7:
          begin
            // Four cospherical corners at random slots, queried on or just off their sphere.
            base = 10'($urandom_range(1019));
            send(isp_pkg::REQ_WRITE, base, 16'd7, 16'd0, 16'd0, '0);
            send(isp_pkg::REQ_WRITE, base + 10'd1, 16'hFFF9, 16'd0, 16'd0, '0);
            send(isp_pkg::REQ_WRITE, base + 10'd2, 16'd0, 16'd7, 16'd0, '0);
            send(isp_pkg::REQ_WRITE, base + 10'd3, 16'd0, 16'd0, 16'd7, '0);
            send(isp_pkg::REQ_POINT, 10'($urandom), 16'd0, 16'hFFF9, 16'($urandom_range(1)),
                 {base + 10'd3, base + 10'd2, base + 10'd1, base});
          end
        8, 9, 10, 11, 12:
          send(isp_pkg::REQ_POINT, 10'($urandom), rand_coord(), rand_coord(), rand_coord(),
               pick_corners());
        13, 14, 15, 16, 17:
          send(isp_pkg::REQ_STORED, pick_written(), 16'($urandom), 16'($urandom),
               16'($urandom), pick_corners());
        default:
          send(isp_pkg::REQ_NONE, 10'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 40'($urandom) | (40'($urandom) << 32));
      endcase
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("** insphere_sign_predicate_core: PASSED **");
    end else begin
      $display("** insphere_sign_predicate_core: FAILED **");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/isp_pkg.sv
rtl/insphere_sign_predicate_core.sv
sim/insphere_sign_predicate_core_checker.sv
sim/insphere_sign_predicate_core_test.sv
